// ===== rtl/core/ltric_pkg.sv =====
package ltric_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_NONE = 3'd5;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // One command for the back end: apply op with operand; on finish, apply
    // tail with a zero operand and then emit the result.
    typedef struct packed {
        logic [2:0]             op;
        logic [VALUE_WIDTH-1:0] operand;
        logic                   finish;
        logic [2:0]             tail;
    } cmd_t;

    function automatic logic [2:0] decode_op(input logic [7:0] c);
        logic [2:0] r;
        unique case (c)
            CH_PLUS:  r = OP_ADD;
            CH_MINUS: r = OP_SUB;
            CH_STAR:  r = OP_MUL;
            CH_SLASH: r = OP_DIV;
            default:  r = OP_NONE;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/ltric_front.sv =====
module ltric_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] symbol
    input  logic              s_tlast,
    output logic              cmd_push,
    output ltric_pkg::cmd_t   cmd,
    input  logic              cmd_full
);
    import ltric_pkg::*;

    logic [VALUE_WIDTH-1:0] operand_reg, operand_next;
    logic                   neg_reg, neg_next;
    logic                   in_op_reg, in_op_next;
    logic [2:0]             pend_reg, pend_next;

    logic                   accept;
    logic                   is_digit;
    logic                   is_sign;
    logic [VALUE_WIDTH-1:0] times10;
    logic [VALUE_WIDTH-1:0] op_upd;
    logic                   neg_upd;
    logic [VALUE_WIDTH-1:0] signed_operand;
    logic [2:0]             decoded;

    assign s_tready = !cmd_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
        is_sign  = !is_digit && !in_op_reg && (s_tdata == CH_PLUS || s_tdata == CH_MINUS);
        times10  = (operand_reg << 3) + (operand_reg << 1);
        op_upd   = is_digit ? times10 + VALUE_WIDTH'(s_tdata[3:0]) : operand_reg;
        neg_upd  = is_sign ? (s_tdata == CH_MINUS) : neg_reg;
        signed_operand = neg_upd ? (~op_upd + 1'b1) : op_upd;
        decoded  = decode_op(s_tdata);

        cmd.op      = pend_reg;
        cmd.operand = signed_operand;
        cmd.finish  = s_tlast;
        cmd.tail    = (is_digit || is_sign) ? OP_NONE : decoded;
        cmd_push    = accept && (!(is_digit || is_sign) || s_tlast);
    end

    always_comb begin
        operand_next = operand_reg;
        neg_next     = neg_reg;
        in_op_next   = in_op_reg;
        pend_next    = pend_reg;
        if (accept) begin
            priority if (s_tlast) begin
                operand_next = '0;
                neg_next     = 1'b0;
                in_op_next   = 1'b0;
                pend_next    = OP_LOAD;
            end else if (is_digit) begin
                operand_next = op_upd;
                in_op_next   = 1'b1;
            end else if (is_sign) begin
                neg_next     = neg_upd;
                in_op_next   = 1'b1;
            end else begin
                operand_next = '0;
                neg_next     = 1'b0;
                in_op_next   = 1'b0;
                pend_next    = decoded;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            operand_reg <= '0;
            neg_reg     <= 1'b0;
            in_op_reg   <= 1'b0;
            pend_reg    <= OP_LOAD;
        end else begin
            operand_reg <= operand_next;
            neg_reg     <= neg_next;
            in_op_reg   <= in_op_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

// ===== rtl/core/ltric_cmd_queue.sv =====
module ltric_cmd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ltric_pkg::cmd_t   din,
    output logic              full,
    input  logic              pop,
    output ltric_pkg::cmd_t   dout,
    output logic              valid
);
    import ltric_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign valid   = (count_reg != '0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/ltric_back.sv =====
module ltric_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    input  ltric_pkg::cmd_t               cmd,
    output logic                          cmd_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ltric_pkg::VALUE_WIDTH-1:0] m_value,
    output logic                          m_dz
);
    import ltric_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam int W = VALUE_WIDTH;

    logic [1:0]       state_reg, state_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic             dz_reg, dz_next;
    logic             fin_reg, fin_next;
    logic [2:0]       tail_reg, tail_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     div_reg, div_next;
    logic             qneg_reg, qneg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [W-1:0]     out_value_reg, out_value_next;
    logic             out_dz_reg, out_dz_next;

    logic [W-1:0]     product;
    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic [W-1:0]     quo_step;
    logic [W-1:0]     tail_acc;
    logic             tail_dz;
    logic             out_free;

    assign m_tvalid = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_dz     = out_dz_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign cmd_pop  = cmd_valid && (state_reg == ST_IDLE);
    assign product  = acc_reg * cmd.operand;

    // one restoring divide step per cycle on magnitudes
    always_comb begin
        shifted  = {rem_reg, quo_reg[W-1]};
        diff     = shifted - {1'b0, div_reg};
        quo_step = {quo_reg[W-2:0], !diff[W]};
    end

    // trailing operator applied to a missing (zero) operand
    always_comb begin
        tail_acc = acc_reg;
        tail_dz  = dz_reg;
        unique case (tail_reg)
            OP_LOAD, OP_MUL: tail_acc = '0;
            OP_DIV:          tail_dz  = 1'b1;
            default:         tail_acc = acc_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        dz_next        = dz_reg;
        fin_next       = fin_reg;
        tail_next      = tail_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        qneg_next      = qneg_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_dz_next    = out_dz_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    fin_next   = cmd.finish;
                    tail_next  = cmd.tail;
                    state_next = cmd.finish ? ST_FIN : ST_IDLE;
                    unique case (cmd.op)
                        OP_LOAD: acc_next = cmd.operand;
                        OP_ADD:  acc_next = acc_reg + cmd.operand;
                        OP_SUB:  acc_next = acc_reg - cmd.operand;
                        OP_MUL:  acc_next = product;
                        OP_DIV: begin
                            if (cmd.operand == '0) begin
                                dz_next = 1'b1;
                            end else begin
                                rem_next   = '0;
                                quo_next   = acc_reg[W-1] ? ~acc_reg + 1'b1 : acc_reg;
                                div_next   = cmd.operand[W-1] ? ~cmd.operand + 1'b1
                                                              : cmd.operand;
                                qneg_next  = acc_reg[W-1] ^ cmd.operand[W-1];
                                cnt_next   = CNT_W'(W);
                                state_next = ST_DIV;
                            end
                        end
                        default: acc_next = acc_reg;
                    endcase
                end
            end
            ST_DIV: begin
                rem_next = diff[W] ? shifted[W-1:0] : diff[W-1:0];
                quo_next = quo_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    acc_next   = qneg_reg ? ~quo_step + 1'b1 : quo_step;
                    state_next = fin_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_value_next = tail_acc;
                    out_dz_next    = tail_dz;
                    acc_next       = '0;
                    dz_next        = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        div_reg       <= div_next;
        qneg_reg      <= qneg_next;
        cnt_reg       <= cnt_next;
        fin_reg       <= fin_next;
        tail_reg      <= tail_next;
        out_value_reg <= out_value_next;
        out_dz_reg    <= out_dz_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            dz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            dz_reg        <= dz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (div_reg != '0))
        else $error("divider running with zero divisor");

    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free) |=> (acc_reg == '0 && !dz_reg && m_tvalid))
        else $error("state not cleared after result");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> (state_reg == ST_IDLE))
        else $error("command taken while busy");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg != '0))
        else $error("divide counter underflow");

endmodule

// ===== rtl/core/left_to_right_integer_calculator.sv =====
// Left-to-right calculator: evaluates an ASCII expression, no precedence.
// Input word (s_*): one character per word in s_tdata[7:0]; s_tlast marks
// the final character of an expression. Operands are an optional sign and
// decimal digits; + - * / are operators, anything else is a no-op operator.
// Output word (m_*): one per expression, issued after the s_tlast word.
// m_tdata holds the 32-bit two's complement value, m_tuser is set when a
// division by zero was skipped (accumulator left as it was).
// Digits and signs are absorbed by the front end; unless one ends the
// expression, it issues no command. An operator is applied as the back end
// takes it, except a divide by a nonzero operand, which runs the restoring
// divider on magnitudes (one quotient bit per cycle). The last word's command
// waits behind earlier ones, then passes ST_FIN into the output register.
// A two-entry command queue sits between front and back, so characters
// keep flowing while the back end divides until the queue fills.
// When m_tready is low the result stays in the output register; the back
// end keeps working and only stalls when it has a second result to issue.
// Reset (aresetn low, synchronous) clears the accumulator, the pending
// operator (next operand loads the accumulator) and the sticky flag.
module left_to_right_integer_calculator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] symbol
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ltric_pkg::TDATA_W-1:0]  m_tdata,   // [VALUE_WIDTH-1:0] value
    output logic                           m_tuser    // [0] divide_by_zero
);
    import ltric_pkg::*;

    cmd_t                   push_cmd;
    cmd_t                   head_cmd;
    logic                   cmd_push;
    logic                   cmd_full;
    logic                   cmd_valid;
    logic                   cmd_pop;
    logic [VALUE_WIDTH-1:0] value;

    ltric_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd_push (cmd_push),
        .cmd      (push_cmd),
        .cmd_full (cmd_full)
    );

    ltric_cmd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (cmd_push),
        .din     (push_cmd),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .dout    (head_cmd),
        .valid   (cmd_valid)
    );

    ltric_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_value   (value),
        .m_dz      (m_tuser)
    );

    assign m_tdata = TDATA_W'(value);

endmodule

// ===== bench/tb_left_to_right_integer_calculator.sv =====
module tb_left_to_right_integer_calculator;
    timeunit 1ns;
    timeprecision 1ps;

    import ltric_pkg::*;

    localparam int W           = VALUE_WIDTH;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 40;
    localparam int SYMBOL_GOAL = 650;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;

    int cycle_count  = 0;
    int symbols_sent = 0;
    bit idle_free    = 1'b0;

    left_to_right_integer_calculator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Evaluates the expression as characters are accepted and holds the
    // values still owed by the block.
    class calc_scoreboard;
        typedef struct {
            logic [W-1:0] value;
            logic         div_zero;
        } calc_result_t;

        logic [W-1:0]  acc;
        logic [W-1:0]  mag;
        logic          neg_sign;
        logic          digits_open;
        logic          div_zero_seen;
        logic [2:0]    pend_op;
        calc_result_t  results_due[$];
        int            errors;

        function new();
            errors = 0;
            clear_expression();
        endfunction

        function void clear_expression();
            acc           = '0;
            mag           = '0;
            neg_sign      = 1'b0;
            digits_open   = 1'b0;
            div_zero_seen = 1'b0;
            pend_op       = OP_LOAD;
        endfunction

        function logic [W-1:0] div_toward_zero(logic [W-1:0] a, logic [W-1:0] b);
            logic [W-1:0] ua;
            logic [W-1:0] ub;
            logic [W-1:0] q;
            ua = a[W-1] ? -a : a;
            ub = b[W-1] ? -b : b;
            q  = ua / ub;
            return (a[W-1] ^ b[W-1]) ? -q : q;
        endfunction

        function void fold_operand();
            logic [W-1:0] n;
            n = neg_sign ? -mag : mag;
            case (pend_op)
                OP_LOAD: acc = n;
                OP_ADD:  acc = acc + n;
                OP_SUB:  acc = acc - n;
                OP_MUL:  acc = acc * n;
                OP_DIV: begin
                    if (n == '0)
                        div_zero_seen = 1'b1;
                    else
                        acc = div_toward_zero(acc, n);
                end
                default: ;
            endcase
            mag         = '0;
            neg_sign    = 1'b0;
            digits_open = 1'b0;
        endfunction

        function logic [2:0] op_of(logic [7:0] c);
            case (c)
                CH_PLUS:  return OP_ADD;
                CH_MINUS: return OP_SUB;
                CH_STAR:  return OP_MUL;
                CH_SLASH: return OP_DIV;
                default:  return OP_NONE;
            endcase
        endfunction

        function void note_symbol(logic [7:0] c, logic lst);
            calc_result_t r;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                mag         = mag * 10 + W'(c - CH_ZERO);
                digits_open = 1'b1;
            end else if (!digits_open && (c == CH_PLUS || c == CH_MINUS)) begin
                neg_sign    = (c == CH_MINUS);
                digits_open = 1'b1;
            end else begin
                fold_operand();
                pend_op = op_of(c);
            end
            if (lst) begin
                fold_operand();
                r.value    = acc;
                r.div_zero = div_zero_seen;
                results_due.push_back(r);
                clear_expression();
            end
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [W-1:0] value, logic div_zero);
            calc_result_t want;
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("result %0d with none pending", $signed(value)));
                return;
            end
            want = results_due.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("value %0d, want %0d",
                                          $signed(value), $signed(want.value)));
            if (div_zero !== want.div_zero)
                report_mismatch($sformatf("divide_by_zero %b, want %b",
                                          div_zero, want.div_zero));
        endtask
    endclass

    calc_scoreboard sb;

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** left_to_right_integer_calculator: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_symbol(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[W-1:0], m_tuser);
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(30, 80);
    endfunction

    task automatic send_symbol(logic [7:0] c, logic lst);
        int gap;
        gap = (idle_free || $urandom_range(0, 9) < 6) ? 0 : idle_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        symbols_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_symbol(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 9))
            0, 1:    return CH_PLUS;
            2, 3:    return CH_MINUS;
            4, 5:    return CH_STAR;
            6, 7:    return CH_SLASH;
            8:       return 8'($urandom_range(0, 255));
            default: return CH_SLASH;
        endcase
    endfunction

    // expression with random content, some operands left out
    task automatic send_expression();
        logic [7:0] text[$];
        logic [7:0] op;
        int         terms;
        int         ndig;
        int         r;
        op    = CH_PLUS;
        terms = $urandom_range(1, 4);
        for (int k = 0; k < terms; k++) begin
            if (k > 0) begin
                op = pick_operator();
                text.push_back(op);
            end
            if ($urandom_range(0, 9) == 0)
                continue;
            if ($urandom_range(0, 3) == 0)
                text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            if (op == CH_SLASH && $urandom_range(0, 4) == 0) begin
                text.push_back(CH_ZERO);
                continue;
            end
            r = $urandom_range(0, 99);
            if (r < 5)
                ndig = 0;
            else if (r < 85)
                ndig = $urandom_range(1, 3);
            else if (r < 97)
                ndig = $urandom_range(4, 9);
            else
                ndig = $urandom_range(10, 14);
            for (int d = 0; d < ndig; d++)
                text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 11) == 0)
            text.push_back(pick_operator());
        if (text.size() == 0)
            text.push_back(8'($urandom_range(0, 255)));
        foreach (text[i])
            send_symbol(text[i], i == text.size() - 1);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) send_symbol(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    // Result side: random stalls, quiet stretches, and two long hold-offs
    // that let the command queue fill and back up the input.
    initial begin : result_sink
        int  cyc;
        int  stall_left;
        bit  steady;
        cyc        = 0;
        stall_left = 0;
        steady     = 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 250 == 0)
                steady = ($urandom_range(0, 2) == 0);
            if (cyc == 700 || cyc == 3000)
                stall_left = 400;
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                m_tready   <= 1'b0;
                stall_left = idle_length() - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // most negative over minus one, divide by zero, trailing operator
        send_text("-2147483648/-1");
        send_text("5/0");
        send_text("3+");
        // sign then minus operator, missing operands, NUL and 0xFF as no-op operators
        send_symbol(CH_PLUS, 1'b0);
        send_symbol(CH_MINUS, 1'b0);
        send_symbol(CH_STAR, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(CH_NINE, 1'b1);

        while (symbols_sent < SYMBOL_GOAL) begin
            idle_free = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_expression();
        end
        s_tvalid <= 1'b0;

        while (sb.results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (sb.errors == 0 && sb.results_due.size() == 0)
            $display("** left_to_right_integer_calculator: PASSED **");
        else
            $display("** left_to_right_integer_calculator: FAILED **");
        $finish;
    end
endmodule
